### rtl/core/geneve_header_option_parser_defines.svh
// Assertion macros for the Geneve header and option parser.
`ifndef GENEVE_HEADER_OPTION_PARSER_DEFINES_SVH
`define GENEVE_HEADER_OPTION_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define GHOP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser assertion failed");
// Antecedent implies consequent in the next cycle.
`define GHOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser assertion failed");
`else
`define GHOP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GHOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/ghop_pkg.sv
// Types and constants shared by the Geneve header and option parser.
package ghop_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_OPTIONS = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REC_HEADER   = 2'd0,
    REC_OPTION   = 2'd1,
    REC_DATA     = 2'd2,
    REC_ERROR    = 2'd3
  } rec_kind_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_BAD_VERSION = 3'd1,
    ERR_SHORT_HDR   = 3'd2,
    ERR_TRUNCATED   = 3'd3,
    ERR_BAD_OPT_LEN = 3'd4
  } err_code_t;

  localparam logic [2:0] HDR_LAST_INDEX = 3'd7;
  localparam int unsigned OPT_CRIT_BIT  = 7;
  localparam logic [1:0] VERB_OPTIONS   = 2'd1;
  localparam logic [1:0] VERB_DATA      = 2'd2;
  localparam logic [1:0] VERB_RESET     = 2'd1;

  typedef struct packed {
    rec_kind_t   kind;
    err_code_t   err;
    logic [7:0]  flags;
    logic [15:0] protocol;
    logic [23:0] network_id;
    logic [7:0]  reserved;
    logic [7:0]  options_length;
    logic [15:0] tlv_class;
    logic [7:0]  tlv_type;
    logic        opt_critical;
    logic [7:0]  opt_length;
    logic [31:0] data_word;
  } rec_t;

endpackage

### rtl/core/ghop_if.sv
// Stream interfaces for packet bytes in and parsed records out.
interface ghop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ghop_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  error_code;
  logic [7:0]  header_flags;
  logic [15:0] protocol_type;
  logic [23:0] network_id;
  logic [7:0]  reserved_byte;
  logic [7:0]  options_length;
  logic [15:0] option_class;
  logic [7:0]  option_type;
  logic        option_critical;
  logic [7:0]  option_length;
  logic [31:0] data_word;

  modport source (
    output valid, output record_kind, output error_code, output header_flags,
    output protocol_type, output network_id, output reserved_byte,
    output options_length, output option_class, output option_type,
    output option_critical, output option_length, output data_word,
    input ready
  );
  modport sink (
    input valid, input record_kind, input error_code, input header_flags,
    input protocol_type, input network_id, input reserved_byte,
    input options_length, input option_class, input option_type,
    input option_critical, input option_length, input data_word,
    output ready
  );
endinterface

### rtl/core/geneve_header_option_parser.sv
// Geneve base header and option TLV parser, one packet byte per transfer.
//
// Usage: feed the packet bytes in wire order on in_ch, with last_byte set on
// the final byte; the next byte starts a new packet. The block takes one byte
// every cycle unless stalled and registers at most one record per byte in
// a single result register. A byte is held off only while that register
// still holds a record the consumer has not taken, so the sustained rate is
// one byte per cycle whenever out_ch is ready. A header record appears on the
// eighth byte; at verbosity 1 or more each option header follows on its
// length byte, and at verbosity 2 or 3 each four-byte option data word on its
// last byte. Errors come as error records: a bad version on the eighth byte,
// a short header on an early last byte, a bad option length on the length
// byte (verbosity 1 or more), and truncation on a last byte that arrives with
// option bytes still missing. On a truncation error, drop every record
// already delivered for that packet. After an error the rest of the packet
// is skipped. Write cfg_wdata (verbosity) only while the block is idle.
`include "geneve_header_option_parser_defines.svh"

module geneve_header_option_parser
  import ghop_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ghop_in_if.sink    in_ch,
  ghop_out_if.source out_ch
);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  header_index_r, header_index_nxt;
  logic [7:0]  ver_opt_r, ver_opt_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] protocol_r, protocol_nxt;
  logic [23:0] network_id_r, network_id_nxt;
  logic [7:0]  options_left_r, options_left_nxt;
  logic [6:0]  opt_index_r, opt_index_nxt;
  logic [15:0] tlv_class_r, tlv_class_nxt;
  logic [7:0]  tlv_type_r, tlv_type_nxt;
  logic [7:0]  opt_length_r, opt_length_nxt;
  logic [23:0] word_acc_r, word_acc_nxt;
  logic [1:0]  verbosity_r;

  // Result register
  rec_t        rec_r, rec_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        emit;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  hdr_opt_bytes;
  logic [7:0]  left_dec;
  logic [7:0]  new_opt_body;
  logic [7:0]  idx_inc;

  // Accept a byte unless a pending record is stalled.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;

  assign hdr_opt_bytes = {ver_opt_r[5:0], 2'b00};
  assign left_dec      = (options_left_r != 8'd0) ? options_left_r - 8'd1 : options_left_r;
  assign new_opt_body  = {1'b0, b[4:0], 2'b00};
  assign idx_inc       = {1'b0, opt_index_r} + 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    header_index_nxt = header_index_r;
    ver_opt_nxt      = ver_opt_r;
    flags_nxt        = flags_r;
    protocol_nxt     = protocol_r;
    network_id_nxt   = network_id_r;
    options_left_nxt = options_left_r;
    opt_index_nxt    = opt_index_r;
    tlv_class_nxt    = tlv_class_r;
    tlv_type_nxt     = tlv_type_r;
    opt_length_nxt   = opt_length_r;
    word_acc_nxt     = word_acc_r;
    rec_nxt          = '0;
    emit             = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        case (header_index_r)
          3'd0: ver_opt_nxt = b;
          3'd1: flags_nxt = b;
          3'd2: protocol_nxt = {b, 8'h00};
          3'd3: protocol_nxt = {protocol_r[15:8], b};
          3'd4: network_id_nxt = {b, 16'h0000};
          3'd5: network_id_nxt = {network_id_r[23:16], b, 8'h00};
          3'd6: network_id_nxt = {network_id_r[23:8], b};
          default: ;
        endcase
        if (header_index_r != HDR_LAST_INDEX) begin
          if (last) begin
            header_index_nxt = 3'd0;
            rec_nxt.kind     = REC_ERROR;
            rec_nxt.err      = ERR_SHORT_HDR;
            emit             = 1'b1;
          end else begin
            header_index_nxt = header_index_r + 3'd1;
          end
        end else begin
          header_index_nxt = 3'd0;
          options_left_nxt = 8'd0;
          opt_index_nxt    = 7'd0;
          emit             = 1'b1;
          if (ver_opt_r[7:6] != 2'b00) begin
            rec_nxt.kind = REC_ERROR;
            rec_nxt.err  = ERR_BAD_VERSION;
            phase_nxt    = last ? PH_HEADER : PH_SKIP;
          end else if (last && hdr_opt_bytes != 8'd0) begin
            // Options promised but the packet ends here.
            rec_nxt.kind = REC_ERROR;
            rec_nxt.err  = ERR_TRUNCATED;
            phase_nxt    = PH_HEADER;
          end else begin
            rec_nxt.kind           = REC_HEADER;
            rec_nxt.err            = ERR_OK;
            rec_nxt.flags          = flags_r;
            rec_nxt.protocol       = protocol_r;
            rec_nxt.network_id     = network_id_r;
            rec_nxt.reserved       = b;
            rec_nxt.options_length = hdr_opt_bytes;
            if (last) begin
              phase_nxt = PH_HEADER;
            end else begin
              options_left_nxt = hdr_opt_bytes;
              phase_nxt        = (hdr_opt_bytes != 8'd0) ? PH_OPTIONS : PH_PAYLOAD;
            end
          end
        end
      end

      PH_OPTIONS: begin
        options_left_nxt = left_dec;
        if (last && left_dec != 8'd0) begin
          phase_nxt     = PH_HEADER;
          opt_index_nxt = 7'd0;
          rec_nxt.kind  = REC_ERROR;
          rec_nxt.err   = ERR_TRUNCATED;
          emit          = 1'b1;
        end else if (opt_index_r == 7'd3 && new_opt_body > left_dec) begin
          // Option runs past the option area: skip the rest.
          opt_length_nxt = 8'd4 + new_opt_body;
          opt_index_nxt  = 7'd0;
          phase_nxt      = last ? PH_HEADER : PH_SKIP;
          if (verbosity_r >= VERB_OPTIONS) begin
            rec_nxt.kind         = REC_ERROR;
            rec_nxt.err          = ERR_BAD_OPT_LEN;
            rec_nxt.tlv_class    = tlv_class_r;
            rec_nxt.tlv_type     = tlv_type_r;
            rec_nxt.opt_critical = tlv_type_r[OPT_CRIT_BIT];
            rec_nxt.opt_length   = 8'd4 + new_opt_body;
            emit                 = 1'b1;
          end
        end else begin
          if (opt_index_r < 7'd4) begin
            case (opt_index_r[1:0])
              2'd0: tlv_class_nxt = {b, 8'h00};
              2'd1: tlv_class_nxt = {tlv_class_r[15:8], b};
              2'd2: tlv_type_nxt = b;
              default: opt_length_nxt = 8'd4 + new_opt_body;
            endcase
            if (opt_index_r == 7'd3) begin
              if (verbosity_r >= VERB_OPTIONS) begin
                rec_nxt.kind         = REC_OPTION;
                rec_nxt.err          = ERR_OK;
                rec_nxt.tlv_class    = tlv_class_r;
                rec_nxt.tlv_type     = tlv_type_r;
                rec_nxt.opt_critical = tlv_type_r[OPT_CRIT_BIT];
                rec_nxt.opt_length   = 8'd4 + new_opt_body;
                emit                 = 1'b1;
              end
              opt_index_nxt = (new_opt_body == 8'd0) ? 7'd0 : 7'd4;
            end else begin
              opt_index_nxt = opt_index_r + 7'd1;
            end
          end else begin
            if (opt_index_r[1:0] == 2'd3) begin
              if (verbosity_r >= VERB_DATA) begin
                rec_nxt.kind         = REC_DATA;
                rec_nxt.err          = ERR_OK;
                rec_nxt.tlv_class    = tlv_class_r;
                rec_nxt.tlv_type     = tlv_type_r;
                rec_nxt.opt_critical = tlv_type_r[OPT_CRIT_BIT];
                rec_nxt.opt_length   = opt_length_r;
                rec_nxt.data_word    = {word_acc_r, b};
                emit                 = 1'b1;
              end
            end else begin
              word_acc_nxt = {word_acc_r[15:0], b};
            end
            opt_index_nxt = (idx_inc >= opt_length_r) ? 7'd0 : idx_inc[6:0];
          end
          if (last) begin
            phase_nxt     = PH_HEADER;
            opt_index_nxt = 7'd0;
          end else if (left_dec == 8'd0) begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        if (last) begin
          phase_nxt = PH_HEADER;
        end
      end

      default: begin
        // Skip: keep counting option bytes so truncation is still seen.
        options_left_nxt = left_dec;
        if (last) begin
          phase_nxt = PH_HEADER;
          if (left_dec != 8'd0) begin
            options_left_nxt = 8'd0;
            rec_nxt.kind     = REC_ERROR;
            rec_nxt.err      = ERR_TRUNCATED;
            emit             = 1'b1;
          end
        end
      end
    endcase
  end

  // Load a new record on accept, drop it once transferred.
  always_comb begin
    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_index_r <= 3'd0;
      ver_opt_r      <= 8'd0;
      flags_r        <= 8'd0;
      protocol_r     <= 16'd0;
      network_id_r   <= 24'd0;
      options_left_r <= 8'd0;
      opt_index_r    <= 7'd0;
      tlv_class_r    <= 16'd0;
      tlv_type_r     <= 8'd0;
      opt_length_r   <= 8'd0;
      word_acc_r     <= 24'd0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r        <= phase_nxt;
        header_index_r <= header_index_nxt;
        ver_opt_r      <= ver_opt_nxt;
        flags_r        <= flags_nxt;
        protocol_r     <= protocol_nxt;
        network_id_r   <= network_id_nxt;
        options_left_r <= options_left_nxt;
        opt_index_r    <= opt_index_nxt;
        tlv_class_r    <= tlv_class_nxt;
        tlv_type_r     <= tlv_type_nxt;
        opt_length_r   <= opt_length_nxt;
        word_acc_r     <= word_acc_nxt;
      end
    end
  end

  // Verbosity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verbosity_r <= VERB_RESET;
    end else if (cfg_we) begin
      verbosity_r <= cfg_wdata;
    end
  end

  // Record payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.record_kind     = rec_r.kind;
  assign out_ch.error_code      = rec_r.err;
  assign out_ch.header_flags    = rec_r.flags;
  assign out_ch.protocol_type   = rec_r.protocol;
  assign out_ch.network_id      = rec_r.network_id;
  assign out_ch.reserved_byte   = rec_r.reserved;
  assign out_ch.options_length  = rec_r.options_length;
  assign out_ch.option_class    = rec_r.tlv_class;
  assign out_ch.option_type     = rec_r.tlv_type;
  assign out_ch.option_critical = rec_r.opt_critical;
  assign out_ch.option_length   = rec_r.opt_length;
  assign out_ch.data_word       = rec_r.data_word;

  // Checks
  `GHOP_ASSERT_SAME(a_opt_phase_has_bytes, clk, rst_n, phase_r == PH_OPTIONS, options_left_r != 0)
  `GHOP_ASSERT_SAME(a_hdr_index_in_header, clk, rst_n, header_index_r != 3'd0, phase_r == PH_HEADER)
  `GHOP_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready)
  `GHOP_ASSERT_SAME(a_header_rec_ok, clk, rst_n, out_valid_r && rec_r.kind == REC_HEADER, rec_r.err == ERR_OK)

endmodule
